// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define SRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that cons holds in the cycle after ante
`define SRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sra_pkg.sv =====
package sra_pkg;

  localparam int CAP_W   = 29;
  localparam int OFF_W   = 28;
  localparam int ID_W    = 32;
  localparam int VAL_W   = 64;
  localparam int REQ_W   = 48;
  localparam int FB_W    = 32;
  localparam int ACT_W   = 2;
  localparam int STAT_W  = 2;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

  localparam logic [CAP_W-1:0] CAP_RESET = 29'd16777216;

  localparam int ALIGN_BYTES_DEF = 256;
  localparam int MAX_SPANS_DEF   = 64;

  typedef enum logic [ACT_W-1:0] {
    ACT_ACQUIRE = 2'd0,
    ACT_CLOSE   = 2'd1,
    ACT_RECLAIM = 2'd2,
    ACT_FRAME   = 2'd3
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SPACE   = 2'd1,
    STAT_TABLE_FULL = 2'd2,
    STAT_UNKNOWN_ID = 2'd3
  } stat_t;

  typedef struct packed {
    logic load;
    logic acq_mul;
    logic acq_scale;
    logic acq_align;
    logic acq_place;
    logic acq_commit;
    logic close_exec;
    logic rec_step;
    logic frame_clear;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic table_empty;
    logic rec_ok;
  } dp_stat_t;

endpackage

// ===== hdl/sra_ram.sv =====
module sra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/sra_ctrl.sv =====
`include "assert_macros.svh"

module sra_ctrl
  import sra_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACT_W-1:0] action,
  input  dp_stat_t         dp_stat,
  output dp_cmd_t          cmd,
  output logic             busy,
  output logic             out_valid
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_ACQ_MUL   = 10'b00_0000_0010,
    S_ACQ_SCALE = 10'b00_0000_0100,
    S_ACQ_ALIGN = 10'b00_0000_1000,
    S_ACQ_PLACE = 10'b00_0001_0000,
    S_ACQ_COMMIT= 10'b00_0010_0000,
    S_CLOSE     = 10'b00_0100_0000,
    S_REC_ADDR  = 10'b00_1000_0000,
    S_REC_CHK   = 10'b01_0000_0000,
    S_FRAME     = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (act_t'(action))
            ACT_ACQUIRE: state_nxt = S_ACQ_MUL;
            ACT_CLOSE:   state_nxt = S_CLOSE;
            ACT_RECLAIM: state_nxt = S_REC_ADDR;
            ACT_FRAME:   state_nxt = S_FRAME;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACQ_MUL: begin
        cmd.acq_mul = 1'b1;
        state_nxt   = S_ACQ_SCALE;
      end
      S_ACQ_SCALE: begin
        cmd.acq_scale = 1'b1;
        state_nxt     = S_ACQ_ALIGN;
      end
      S_ACQ_ALIGN: begin
        cmd.acq_align = 1'b1;
        state_nxt     = S_ACQ_PLACE;
      end
      S_ACQ_PLACE: begin
        cmd.acq_place = 1'b1;
        state_nxt     = S_ACQ_COMMIT;
      end
      S_ACQ_COMMIT: begin
        cmd.acq_commit = 1'b1;
        cmd.emit       = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_CLOSE: begin
        cmd.close_exec = 1'b1;
        cmd.emit       = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_REC_ADDR: begin
        if (dp_stat.table_empty) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_REC_CHK;
        end
      end
      S_REC_CHK: begin
        if (dp_stat.rec_ok) begin
          cmd.rec_step = 1'b1;
          state_nxt    = S_REC_ADDR;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FRAME: begin
        cmd.frame_clear = 1'b1;
        cmd.emit        = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= cmd.emit;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = strobe_r;

  `SRA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  `SRA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

endmodule

// ===== hdl/sra_dp.sv =====
`include "assert_macros.svh"

module sra_dp
  import sra_pkg::*;
#(
  parameter int ALIGN_BYTES = ALIGN_BYTES_DEF,
  parameter int MAX_SPANS   = MAX_SPANS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             dp_stat,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [PDATA_W-1:0]   cfg_wdata,
  output logic [PDATA_W-1:0]   cfg_rdata,
  input  logic [CAP_W-1:0]     in_request_size,
  input  logic [ID_W-1:0]      in_span_id,
  input  logic [VAL_W-1:0]     in_transfer_value,
  input  logic [VAL_W-1:0]     in_completed_value,
  output logic [STAT_W-1:0]    out_status,
  output logic [OFF_W-1:0]     out_offset,
  output logic [ID_W-1:0]      out_new_span_id,
  output logic [CAP_W-1:0]     out_used_bytes,
  output logic [CAP_W-1:0]     out_peak_used,
  output logic [REQ_W-1:0]     out_frame_requested,
  output logic [FB_W-1:0]      out_fallback_count
);

  localparam int IW    = $clog2(MAX_SPANS);
  localparam int CW    = $clog2(MAX_SPANS + 1);
  localparam int T_W   = CAP_W + 1;
  localparam int RC_W  = T_W + 1;
  localparam int AL_W  = $clog2(ALIGN_BYTES + 1);
  localparam int SUM_W = CAP_W + 3;
  localparam logic [RC_W-1:0] RECIP = RC_W'((64'd1 << T_W) / ALIGN_BYTES);
  localparam logic [AL_W-1:0] ALIGN = AL_W'(ALIGN_BYTES);

  function automatic logic [IW-1:0] wrap_slot(input logic [IW:0] s);
    logic [IW:0] w;
    w = (s >= (IW+1)'(MAX_SPANS)) ? s - (IW+1)'(MAX_SPANS) : s;
    return w[IW-1:0];
  endfunction

  logic [CAP_W-1:0] cap_r, head_r, used_r, peak_r;
  logic [REQ_W-1:0] req_tot_r;
  logic [FB_W-1:0]  fb_r;
  logic [ID_W-1:0]  oldest_r;
  logic [IW-1:0]    first_r;
  logic [CW-1:0]    count_r;

  logic [CAP_W-1:0] req_r;
  logic [ID_W-1:0]  sid_r;
  logic [VAL_W-1:0] tval_r, done_r;
  logic [T_W-1:0]   t_r, q_r, prod_r, aligned_r;
  logic [CAP_W-1:0] start_r, skip_r;
  logic [STAT_W-1:0] status_r;
  logic [OFF_W-1:0]  offset_r;
  logic [ID_W-1:0]   new_id_r;

  logic [CAP_W-1:0] rd_bytes;
  logic             rd_closed;
  logic [VAL_W-1:0] rd_value;

  logic [T_W+RC_W-1:0] mul1;
  logic [T_W+AL_W-1:0] mul2;
  logic [T_W-1:0]      rem, rem_fix;
  logic                wrap;
  logic [SUM_W-1:0]    place_sum, fit_sum, head_sum, bytes_sum;
  logic                full, no_space, acq_ok;
  logic [IW-1:0]       acq_slot, close_slot, first_nxt;
  logic [ID_W-1:0]     rel;
  logic                hit;
  logic [REQ_W:0]      req_sum;
  logic [REQ_W-1:0]    req_tot_nxt;
  logic [CAP_W-1:0]    used_nxt;
  logic                bytes_we, val_we;
  logic [IW-1:0]       val_waddr;
  logic [VAL_W:0]      val_wdata, val_rdata;
  logic [STAT_W-1:0]   res_status;
  logic [OFF_W-1:0]    res_offset;
  logic [ID_W-1:0]     res_id;

  assign mul1    = (T_W+RC_W)'(t_r) * (T_W+RC_W)'(RECIP);
  assign mul2    = (T_W+AL_W)'(q_r) * (T_W+AL_W)'(ALIGN);
  assign rem     = t_r - prod_r;
  assign rem_fix = (rem >= T_W'(ALIGN_BYTES)) ? rem - T_W'(ALIGN_BYTES) : rem;

  assign place_sum = SUM_W'(head_r) + SUM_W'(aligned_r);
  assign wrap      = place_sum > SUM_W'(cap_r);

  assign fit_sum   = SUM_W'(used_r) + SUM_W'(skip_r) + SUM_W'(aligned_r);
  assign head_sum  = SUM_W'(start_r) + SUM_W'(aligned_r);
  assign bytes_sum = SUM_W'(skip_r) + SUM_W'(aligned_r);
  assign full      = (count_r == CW'(MAX_SPANS));
  assign no_space  = fit_sum > SUM_W'(cap_r);
  assign acq_ok    = !full && !no_space;
  assign acq_slot  = wrap_slot({1'b0, first_r} + (IW+1)'(count_r));
  assign used_nxt  = fit_sum[CAP_W-1:0];

  assign req_sum     = {1'b0, req_tot_r} + (REQ_W+1)'(req_r);
  assign req_tot_nxt = req_sum[REQ_W] ? {REQ_W{1'b1}} : req_sum[REQ_W-1:0];

  assign rel        = sid_r - oldest_r;
  assign hit        = rel < ID_W'(count_r);
  assign close_slot = wrap_slot({1'b0, first_r} + (IW+1)'(rel[CW-1:0]));

  assign first_nxt = (first_r == IW'(MAX_SPANS - 1)) ? '0 : first_r + 1'b1;

  assign bytes_we  = cmd.acq_commit && acq_ok;
  assign val_we    = bytes_we || (cmd.close_exec && hit);
  assign val_waddr = cmd.close_exec ? close_slot : acq_slot;
  assign val_wdata = cmd.close_exec ? {1'b1, tval_r} : '0;

  sra_ram #(.WIDTH(CAP_W), .DEPTH(MAX_SPANS)) u_bytes_ram (
    .clk   (clk),
    .we    (bytes_we),
    .waddr (acq_slot),
    .wdata (bytes_sum[CAP_W-1:0]),
    .raddr (first_r),
    .rdata (rd_bytes)
  );

  sra_ram #(.WIDTH(VAL_W + 1), .DEPTH(MAX_SPANS)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (first_r),
    .rdata (val_rdata)
  );

  assign rd_closed = val_rdata[VAL_W];
  assign rd_value  = val_rdata[VAL_W-1:0];

  assign dp_stat.table_empty = (count_r == '0);
  assign dp_stat.rec_ok      = rd_closed && (done_r >= rd_value);

  always_comb begin
    res_status = STAT_OK;
    res_offset = '0;
    res_id     = '0;
    if (cmd.acq_commit) begin
      if (full) begin
        res_status = STAT_TABLE_FULL;
      end else if (no_space) begin
        res_status = STAT_NO_SPACE;
      end else begin
        res_offset = start_r[OFF_W-1:0];
        res_id     = oldest_r + ID_W'(count_r);
      end
    end else if (cmd.close_exec && !hit) begin
      res_status = STAT_UNKNOWN_ID;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_request_size;
      sid_r  <= in_span_id;
      tval_r <= in_transfer_value;
      done_r <= in_completed_value;
      t_r    <= T_W'(in_request_size) + T_W'(ALIGN_BYTES - 1);
    end
    if (cmd.acq_mul) begin
      q_r <= mul1[2*T_W-1:T_W];
    end
    if (cmd.acq_scale) begin
      prod_r <= mul2[T_W-1:0];
    end
    if (cmd.acq_align) begin
      aligned_r <= t_r - rem_fix;
    end
    if (cmd.acq_place) begin
      start_r <= wrap ? '0 : head_r;
      skip_r  <= (wrap && (head_r < cap_r)) ? cap_r - head_r : '0;
    end
    if (cmd.emit) begin
      status_r <= res_status;
      offset_r <= res_offset;
      new_id_r <= res_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      head_r    <= '0;
      used_r    <= '0;
      peak_r    <= '0;
      req_tot_r <= '0;
      fb_r      <= '0;
      oldest_r  <= '0;
      first_r   <= '0;
      count_r   <= '0;
    end else begin
      if (cfg_we && (cfg_idx == REG_CAPACITY)) begin
        cap_r <= cfg_wdata[CAP_W-1:0];
      end
      if (cmd.acq_commit) begin
        req_tot_r <= req_tot_nxt;
        if (!acq_ok) begin
          fb_r <= fb_r + 1'b1;
        end else begin
          head_r  <= head_sum[CAP_W-1:0];
          used_r  <= used_nxt;
          count_r <= count_r + 1'b1;
          if (used_nxt > peak_r) begin
            peak_r <= used_nxt;
          end
        end
      end
      if (cmd.rec_step) begin
        used_r   <= (used_r >= rd_bytes) ? used_r - rd_bytes : '0;
        first_r  <= first_nxt;
        count_r  <= count_r - 1'b1;
        oldest_r <= oldest_r + 1'b1;
      end
      if (cmd.frame_clear) begin
        req_tot_r <= '0;
      end
    end
  end

  assign cfg_rdata = (cfg_idx == REG_CAPACITY) ? PDATA_W'(cap_r) : '0;

  assign out_status          = status_r;
  assign out_offset          = offset_r;
  assign out_new_span_id     = new_id_r;
  assign out_used_bytes      = used_r;
  assign out_peak_used       = peak_r;
  assign out_frame_requested = req_tot_r;
  assign out_fallback_count  = fb_r;

  `SRA_ASSERT(a_empty_no_bytes, (count_r != '0) || (used_r == '0), "bytes held with no spans")
  `SRA_ASSERT_NEXT(a_full_stays, cmd.acq_commit && full, count_r == CW'(MAX_SPANS),
                   "span table grew past full")

endmodule

// ===== hdl/staging_ring_allocator.sv =====
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// input     | start / busy         | in_action, in_request_size, in_span_id, in_*_value
// result    | out_valid strobe     | out_status, out_offset, out_new_span_id, stats
// config    | psel/penable/pwrite  | paddr, pwdata, prdata, pready (always high)
//
// An item transfers at an edge with start high and busy low; one result follows.
// Acquire steps through multiply, scale, align, place and commit states: the two-multiply
// alignment, then placement. Close and begin frame each run in their own state; reclaim
// does one span table read and check per freed span through the RAM read port.
// Reset (rst_n low, synchronous) empties the ring and sets capacity to 16 MiB.
// The result strobe lasts one cycle; the receiver cannot stall it.
module staging_ring_allocator
  import sra_pkg::*;
#(
  parameter int ALIGN_BYTES = ALIGN_BYTES_DEF,
  parameter int MAX_SPANS   = MAX_SPANS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [CAP_W-1:0]   in_request_size,
  input  logic [ID_W-1:0]    in_span_id,
  input  logic [VAL_W-1:0]   in_transfer_value,
  input  logic [VAL_W-1:0]   in_completed_value,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic [OFF_W-1:0]   out_offset,
  output logic [ID_W-1:0]    out_new_span_id,
  output logic [CAP_W-1:0]   out_used_bytes,
  output logic [CAP_W-1:0]   out_peak_used,
  output logic [REQ_W-1:0]   out_frame_requested,
  output logic [FB_W-1:0]    out_fallback_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  dp_cmd_t  cmd;
  dp_stat_t dp_stat;
  logic     cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  sra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_action),
    .dp_stat   (dp_stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sra_dp #(
    .ALIGN_BYTES (ALIGN_BYTES),
    .MAX_SPANS   (MAX_SPANS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .dp_stat             (dp_stat),
    .cfg_we              (cfg_we),
    .cfg_idx             (paddr[PADDR_W-1:2]),
    .cfg_wdata           (pwdata),
    .cfg_rdata           (prdata),
    .in_request_size     (in_request_size),
    .in_span_id          (in_span_id),
    .in_transfer_value   (in_transfer_value),
    .in_completed_value  (in_completed_value),
    .out_status          (out_status),
    .out_offset          (out_offset),
    .out_new_span_id     (out_new_span_id),
    .out_used_bytes      (out_used_bytes),
    .out_peak_used       (out_peak_used),
    .out_frame_requested (out_frame_requested),
    .out_fallback_count  (out_fallback_count)
  );

endmodule

// ===== sim/staging_ring_allocator_checker.sv =====
`timescale 1ns / 1ps

module staging_ring_allocator_checker
  import sra_pkg::*;
#(
  parameter int ALIGN_BYTES = ALIGN_BYTES_DEF,
  parameter int MAX_SPANS   = MAX_SPANS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [CAP_W-1:0]   in_request_size,
  input  logic [ID_W-1:0]    in_span_id,
  input  logic [VAL_W-1:0]   in_transfer_value,
  input  logic [VAL_W-1:0]   in_completed_value,
  input  logic               out_valid,
  input  logic [STAT_W-1:0]  out_status,
  input  logic [OFF_W-1:0]   out_offset,
  input  logic [ID_W-1:0]    out_new_span_id,
  input  logic [CAP_W-1:0]   out_used_bytes,
  input  logic [CAP_W-1:0]   out_peak_used,
  input  logic [REQ_W-1:0]   out_frame_requested,
  input  logic [FB_W-1:0]    out_fallback_count,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic [PDATA_W-1:0] prdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending,
  output logic [ID_W-1:0]    held_oldest,
  output int                 held_count
);

  typedef struct {
    stat_t            status;
    logic [OFF_W-1:0] offset;
    logic [ID_W-1:0]  new_id;
    logic [CAP_W-1:0] used;
    logic [CAP_W-1:0] peak;
    logic [REQ_W-1:0] requested;
    logic [FB_W-1:0]  fallbacks;
  } alloc_result_t;

  alloc_result_t    alloc_q[$];

  logic [CAP_W-1:0] ring_cap;
  logic [CAP_W-1:0] head;
  logic [CAP_W-1:0] used;
  logic [CAP_W-1:0] peak;
  logic [REQ_W-1:0] req_sum;
  logic [FB_W-1:0]  fb_sum;
  logic [ID_W-1:0]  oldest;
  int               first;
  int               count;
  logic [CAP_W-1:0] slot_bytes  [MAX_SPANS];
  bit               slot_closed [MAX_SPANS];
  logic [VAL_W-1:0] slot_fence  [MAX_SPANS];

  function automatic alloc_result_t apply_transfer(input act_t act,
                                                   input logic [CAP_W-1:0] req,
                                                   input logic [ID_W-1:0] sid,
                                                   input logic [VAL_W-1:0] fence,
                                                   input logic [VAL_W-1:0] reached);
    alloc_result_t r;
    logic [63:0]   aligned;
    logic [63:0]   start_at;
    logic [63:0]   skip;
    logic [63:0]   sum;
    logic [ID_W-1:0] rel;
    int            slot;
    r.status = STAT_OK;
    r.offset = '0;
    r.new_id = '0;
    case (act)
      ACT_ACQUIRE: begin
        aligned  = ((64'(req) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES))
                   * 64'(ALIGN_BYTES);
        start_at = 64'(head);
        skip     = '0;
        sum      = 64'(req_sum) + 64'(req);
        req_sum  = (sum > 64'hFFFF_FFFF_FFFF) ? '1 : sum[REQ_W-1:0];
        if (start_at + aligned > 64'(ring_cap)) begin
          skip     = (start_at < 64'(ring_cap)) ? 64'(ring_cap) - start_at : 64'd0;
          start_at = '0;
        end
        if (count >= MAX_SPANS) begin
          r.status = STAT_TABLE_FULL;
          fb_sum++;
        end else if (64'(used) + skip + aligned > 64'(ring_cap)) begin
          r.status = STAT_NO_SPACE;
          fb_sum++;
        end else begin
          slot = (first + count) % MAX_SPANS;
          sum  = start_at + aligned;
          head = sum[CAP_W-1:0];
          sum  = 64'(used) + skip + aligned;
          used = sum[CAP_W-1:0];
          if (used > peak) peak = used;
          sum  = skip + aligned;
          slot_bytes[slot]  = sum[CAP_W-1:0];
          slot_closed[slot] = 1'b0;
          slot_fence[slot]  = '0;
          r.offset = start_at[OFF_W-1:0];
          r.new_id = oldest + ID_W'(count);
          count++;
        end
      end
      ACT_CLOSE: begin
        rel = sid - oldest;
        if (rel >= ID_W'(count)) begin
          r.status = STAT_UNKNOWN_ID;
        end else begin
          slot = (first + int'(rel)) % MAX_SPANS;
          slot_closed[slot] = 1'b1;
          slot_fence[slot]  = fence;
        end
      end
      ACT_RECLAIM: begin
        while (count > 0) begin
          if (!slot_closed[first] || reached < slot_fence[first]) break;
          used  = (used >= slot_bytes[first]) ? used - slot_bytes[first] : '0;
          first = (first + 1) % MAX_SPANS;
          count--;
          oldest++;
        end
      end
      default: begin
        req_sum = '0;
      end
    endcase
    r.used      = used;
    r.peak      = peak;
    r.requested = req_sum;
    r.fallbacks = fb_sum;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s expected 0x%0h got 0x%0h", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst_n) begin
      ring_cap = CAP_RESET;
      head     = '0;
      used     = '0;
      peak     = '0;
      req_sum  = '0;
      fb_sum   = '0;
      oldest   = '0;
      first    = 0;
      count    = 0;
      for (int i = 0; i < MAX_SPANS; i++) begin
        slot_bytes[i]  = '0;
        slot_closed[i] = 1'b0;
        slot_fence[i]  = '0;
      end
      alloc_q.delete();
    end else begin
      if (out_valid) begin
        if (alloc_q.size() == 0) begin
          $error("result with no outstanding transfer");
          fail_count++;
        end else begin
          want = alloc_q[0];
          alloc_q.delete(0);
          check_field("status", 64'(want.status), 64'(out_status));
          check_field("offset", 64'(want.offset), 64'(out_offset));
          check_field("new_span_id", 64'(want.new_id), 64'(out_new_span_id));
          check_field("used_bytes", 64'(want.used), 64'(out_used_bytes));
          check_field("peak_used", 64'(want.peak), 64'(out_peak_used));
          check_field("frame_requested", 64'(want.requested), 64'(out_frame_requested));
          check_field("fallback_count", 64'(want.fallbacks), 64'(out_fallback_count));
        end
      end
      if (start && !busy) begin
        alloc_q.insert(alloc_q.size(),
                       apply_transfer(act_t'(in_action), in_request_size, in_span_id,
                                      in_transfer_value, in_completed_value));
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[PADDR_W-1:2] == REG_CAPACITY) ring_cap = pwdata[CAP_W-1:0];
        end else if (paddr[PADDR_W-1:2] == REG_CAPACITY) begin
          check_field("capacity_bytes", 64'(ring_cap), 64'(prdata));
        end
      end
    end
  end

  always @(negedge clk) begin
    pending     <= alloc_q.size();
    held_oldest <= oldest;
    held_count  <= count;
  end

endmodule

// ===== sim/staging_ring_allocator_test.sv =====
`timescale 1ns / 1ps

module staging_ring_allocator_test;
  import sra_pkg::*;

  localparam int NUM_PHASES   = 9;
  localparam int PHASE_ITEMS  = 128;
  localparam logic [CAP_W-1:0] CAP_MAX = 29'd268435456;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [ACT_W-1:0]   in_action;
  logic [CAP_W-1:0]   in_request_size;
  logic [ID_W-1:0]    in_span_id;
  logic [VAL_W-1:0]   in_transfer_value;
  logic [VAL_W-1:0]   in_completed_value;
  logic               out_valid;
  logic [STAT_W-1:0]  out_status;
  logic [OFF_W-1:0]   out_offset;
  logic [ID_W-1:0]    out_new_span_id;
  logic [CAP_W-1:0]   out_used_bytes;
  logic [CAP_W-1:0]   out_peak_used;
  logic [REQ_W-1:0]   out_frame_requested;
  logic [FB_W-1:0]    out_fallback_count;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;
  logic [ID_W-1:0]    held_oldest;
  int                 held_count;

  logic [CAP_W-1:0]   cap_now;
  logic [VAL_W-1:0]   fence_base;

  staging_ring_allocator dut (.*);

  staging_ring_allocator_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send(input act_t act, input logic [CAP_W-1:0] size,
                      input logic [ID_W-1:0] sid, input logic [VAL_W-1:0] tv,
                      input logic [VAL_W-1:0] cv);
    start              <= 1'b1;
    in_action          <= act;
    in_request_size    <= size;
    in_span_id         <= sid;
    in_transfer_value  <= tv;
    in_completed_value <= cv;
    do @(posedge clk); while (busy);
  endtask

  task automatic acquire(input logic [CAP_W-1:0] size);
    send(ACT_ACQUIRE, size, $urandom, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic close_span(input logic [ID_W-1:0] sid, input logic [VAL_W-1:0] tv);
    send(ACT_CLOSE, CAP_W'($urandom), sid, tv, {$urandom, $urandom});
  endtask

  task automatic reclaim(input logic [VAL_W-1:0] cv);
    send(ACT_RECLAIM, CAP_W'($urandom), $urandom, {$urandom, $urandom}, cv);
  endtask

  task automatic begin_frame();
    send(ACT_FRAME, CAP_W'($urandom), $urandom, {$urandom, $urandom},
         {$urandom, $urandom});
  endtask

  task automatic send_random(input int acq_pct, input logic [CAP_W-1:0] size_cap);
    int               pick;
    int               r;
    logic [CAP_W-1:0] size;
    logic [ID_W-1:0]  sid;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 19);
    if (pick < acq_pct) begin
      case (r)
        0:       size = '0;
        1:       size = CAP_W'($urandom_range(0, cap_now));
        2:       size = CAP_W'($urandom_range(0, CAP_MAX));
        default: size = CAP_W'($urandom_range(0, size_cap));
      endcase
      acquire(size);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        if (held_count > 0 && r < 10) sid = held_oldest;
        else if (held_count > 0 && r < 17)
          sid = held_oldest + ID_W'($urandom_range(0, held_count - 1));
        else if (r == 17) sid = held_oldest + ID_W'(held_count);
        else if (r == 18) sid = held_oldest - ID_W'(1);
        else sid = $urandom;
        close_span(sid, fence_base + 64'($urandom_range(0, 63)));
      end else if (pick < 85) begin
        reclaim((r == 0) ? '1 : fence_base + 64'($urandom_range(0, 63)));
      end else begin
        begin_frame();
      end
    end
  endtask

  task automatic cfg_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    cap_now = cap;
    cfg_access(1'b1, {REG_CAPACITY, 2'b00}, PDATA_W'(cap));
    cfg_access(1'b0, {REG_CAPACITY, 2'b00}, $urandom);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  initial begin
    logic [CAP_W-1:0] phase_cap  [NUM_PHASES];
    logic [CAP_W-1:0] phase_size [NUM_PHASES];
    int               phase_acq  [NUM_PHASES];
    int               burst_left;
    int               gap;

    rst_n              = 1'b0;
    start              = 1'b0;
    in_action          = '0;
    in_request_size    = '0;
    in_span_id         = '0;
    in_transfer_value  = '0;
    in_completed_value = '0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cap_now            = CAP_RESET;
    fence_base         = {$urandom, $urandom};

    phase_cap[0] = CAP_RESET;     phase_size[0] = 29'd1048576;  phase_acq[0] = 50;
    phase_cap[1] = CAP_MAX;       phase_size[1] = 29'd1048576;  phase_acq[1] = 70;
    phase_cap[2] = 29'd1;         phase_size[2] = 29'd1;        phase_acq[2] = 50;
    phase_cap[3] = 29'd4133;      phase_size[3] = 29'd2000;     phase_acq[3] = 45;
    phase_cap[4] = 29'd100000;    phase_size[4] = 29'd30000;    phase_acq[4] = 45;
    phase_cap[5] = CAP_MAX;       phase_size[5] = 29'd134217728; phase_acq[5] = 45;
    phase_cap[6] = 29'd300;       phase_size[6] = 29'd300;      phase_acq[6] = 50;
    phase_cap[7] = CAP_W'($urandom_range(1, CAP_MAX));
    phase_size[7] = phase_cap[7] / 29'd4;                       phase_acq[7] = 45;
    phase_cap[8] = CAP_RESET;     phase_size[8] = 29'd2097152;  phase_acq[8] = 55;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    begin_frame();
    acquire(29'd0);
    acquire(29'd1);
    acquire(29'd256);
    acquire(29'd257);
    acquire(CAP_MAX);
    close_span(32'd1, '1);
    close_span(32'd0, 64'd5);
    reclaim(64'd4);
    reclaim(64'd5);
    close_span(32'd100, {$urandom, $urandom});
    close_span(32'hFFFF_FFFF, {$urandom, $urandom});
    reclaim('1);
    close_span(32'd2, 64'd0);
    close_span(32'd3, 64'd0);
    reclaim(64'd0);
    acquire(CAP_RESET - 29'd1024);
    acquire(29'd0);
    acquire(29'd1);
    close_span(32'd4, 64'd0);
    close_span(32'd5, 64'd0);
    reclaim(64'd0);
    acquire(29'h0FFF_FFFF);
    begin_frame();
    start <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p == 3) cfg_access(1'b1, 3'd4, $urandom);
      if (p > 0) set_capacity(phase_cap[p]);
      fence_base = {$urandom, $urandom};
      burst_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          if ($urandom_range(0, 15) == 0) gap = 30;
          if (gap > 0 && n > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_random(phase_acq[p], phase_size[p]);
        burst_left--;
      end
      start <= 1'b0;
    end

    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
